// ===== design/mjct_pkg.sv =====
// Shared types and constants for the multi-joint cubic trajectory block.
`default_nettype none
package mjct_pkg;
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_WINDOW   = 2'd1,
        CMD_DURATION = 2'd2,
        CMD_ENABLE   = 2'd3
    } cmd_t;

    localparam logic KIND_JOINT = 1'b0;
    localparam logic KIND_ACK   = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;
    localparam int   MAX_RESULTS  = 32;

    // One joint entry as kept in the table memory.
    typedef struct packed {
        logic [31:0] t0;
        logic [31:0] tf;
        logic [31:0] x0;
        logic [31:0] xf;
        logic        en;
        logic [31:0] xd;
    } joint_entry_t;

    // Request into the blend unit.
    typedef struct packed {
        logic [31:0] t;
        logic [31:0] t0;
        logic [31:0] tf;
        logic [31:0] x0;
        logic [31:0] xf;
    } blend_req_t;
endpackage
`default_nettype wire

// ===== design/mjct_divider.sv =====
// Restoring divider: quotient of (num << 32) / den, one bit per cycle.
`default_nettype none
module mjct_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quot
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] shifted;
    logic [33:0] diff;

    // num < den, so the remainder stays below den and 33 bits suffice.
    always_comb begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {2'b00, den_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {1'b0, num};
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_next = diff[32:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[32:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
endmodule
`default_nettype wire

// ===== design/mjct_blend.sv =====
// Cubic blend unit: divider, then square and cube on a shared 32x32 multiplier, then the offset multiply.
`default_nettype none
module mjct_blend (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire mjct_pkg::blend_req_t req,
    output logic                      done,
    output logic [31:0]               pos
);
    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_SQ, B_CUBE, B_OFF, B_DONE
    } bstate_t;

    bstate_t     state_reg;
    logic [31:0] x0_reg;
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic [31:0] s_reg;
    logic [31:0] s2_reg;
    logic [32:0] h_reg;
    logic [31:0] pos_reg;
    logic        done_reg;
    logic        before_reg;
    logic        div_done;
    logic [31:0] div_quot;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [34:0] h_raw;
    logic [32:0] delta;
    logic [63:0] off_prod;
    logic [31:0] off;

    mjct_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start && !(req.t < req.t0)),
        .num     (req.t - req.t0),
        .den     (req.tf - req.t0),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        delta = {req.xf[31], req.xf} - {req.x0[31], req.x0};
        mul_a = s_reg;
        mul_b = (state_reg == B_CUBE) ? s2_reg : s_reg;
        prod  = {32'd0, mul_a} * {32'd0, mul_b};
        // h = 3*s2 - 2*s3, where prod holds s3 in the cube step
        h_raw = {3'b000, s2_reg} + {2'b00, s2_reg, 1'b0} - {2'b00, prod[63:32], 1'b0};
        off_prod = {32'd0, mag_reg} * {31'd0, h_reg};
        off   = h_reg[32] ? mag_reg : off_prod[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE: begin
                    if (start) begin
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (before_reg) begin
                        state_reg <= B_DONE;
                    end else if (div_done) begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:   state_reg <= B_CUBE;
                B_CUBE: state_reg <= B_OFF;
                B_OFF:  state_reg <= B_DONE;
                B_DONE: begin
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
        if (start) begin
            x0_reg     <= req.x0;
            neg_reg    <= delta[32];
            mag_reg    <= delta[32] ? 32'(-delta) : delta[31:0];
            before_reg <= req.t < req.t0;
            pos_reg    <= req.x0;
        end
        if (state_reg == B_DIV && div_done) begin
            s_reg <= div_quot;
        end
        if (state_reg == B_SQ) begin
            s2_reg <= prod[63:32];
        end
        if (state_reg == B_CUBE) begin
            h_reg <= (h_raw > 35'h1_0000_0000) ? 33'h1_0000_0000 : h_raw[32:0];
        end
        if (state_reg == B_OFF) begin
            pos_reg <= neg_reg ? (x0_reg - off) : (x0_reg + off);
        end
    end

    assign done = done_reg;
    assign pos  = pos_reg;

    a_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("blend done held");
endmodule
`default_nettype wire

// ===== design/multi_joint_cubic_trajectory.sv =====
// Top level: joint table memory, command sequencer and result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | cmd, joint, positions, times, enable
//  m_      | out       | m_valid / m_ready  | kind, joint_index, desired_pos, claim,
//          |           |                    | status, last
//  cfg     | in        | cfg_we             | cfg_wdata (joint_count)
//
// A set command passes through read, modify, write back and result. A tick
// walks the joints in turn through the same steps, with a blend-unit pass for
// each enabled joint whose end time lies ahead; the blend unit divides bit-serially.
// After reset the sequencer clears every table entry before it accepts a
// request. A stalled result holds the sequencer in place.
`default_nettype none
module multi_joint_cubic_trajectory #(
    parameter int NUM_JOINTS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [4:0]  s_joint,
    input  wire logic [31:0] s_target_pos,
    input  wire logic [31:0] s_current_pos,
    input  wire logic [31:0] s_now,
    input  wire logic [31:0] s_window_start,
    input  wire logic [31:0] s_window_end,
    input  wire logic [31:0] s_duration,
    input  wire logic        s_enable,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [4:0]       m_joint_index,
    output logic [31:0]      m_desired_pos,
    output logic             m_claims_joint,
    output logic             m_status,
    output logic             m_last
);
    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int CW = $clog2(NUM_JOINTS + 1);
    // at most one result per joint, and no more results than one tick may give
    localparam int NA = (NUM_JOINTS > mjct_pkg::MAX_RESULTS) ? mjct_pkg::MAX_RESULTS
                                                            : NUM_JOINTS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EVAL, S_BLEND, S_WRITE, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [5:0]             jc_reg;
    logic [AW-1:0]          addr_reg;
    logic [AW-1:0]          clr_reg;
    logic [5:0]             idx_reg;
    logic [5:0]             n_reg;
    logic [1:0]             cmd_reg;
    logic [4:0]             joint_reg;
    logic [31:0]            tgt_reg, cur_reg, now_reg, ws_reg, we_reg, dur_reg;
    logic                   en_reg;
    mjct_pkg::joint_entry_t mem [NUM_JOINTS];
    mjct_pkg::joint_entry_t rd_reg;
    mjct_pkg::joint_entry_t wr_reg;
    mjct_pkg::joint_entry_t wr_next;
    logic                   we_mem;
    logic [AW-1:0]          wa_mem;
    mjct_pkg::joint_entry_t wd_mem;
    logic                   mv_reg;
    logic                   mk_reg, mc_reg, ms_reg, ml_reg;
    logic [4:0]             mj_reg;
    logic [31:0]            mp_reg;
    logic                   bl_start;
    mjct_pkg::blend_req_t   bl_req;
    logic                   bl_done;
    logic [31:0]            bl_pos;
    logic [5:0]             n_act;
    logic [CW-1:0]          nj;

    assign nj    = CW'(NUM_JOINTS);
    assign n_act = (jc_reg > 6'(NA)) ? 6'(NA) : jc_reg;

    // Table memory, one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we_mem) begin
            mem[wa_mem] <= wd_mem;
        end
        rd_reg <= mem[addr_reg];
    end

    always_comb begin
        we_mem = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
        wa_mem = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
        wd_mem = (state_reg == S_CLEAR) ? '0 : wr_reg;
    end

    // Modified entry for the request in flight; the blend result lands later.
    always_comb begin
        wr_next = rd_reg;
        case (cmd_reg)
            mjct_pkg::CMD_TICK: begin
                if (rd_reg.en && (now_reg >= rd_reg.tf)) begin
                    wr_next.xd = rd_reg.xf;
                    wr_next.en = 1'b0;
                end
            end
            mjct_pkg::CMD_WINDOW: begin
                wr_next.t0 = ws_reg;
                wr_next.tf = we_reg;
                wr_next.x0 = cur_reg;
                wr_next.xf = tgt_reg;
            end
            mjct_pkg::CMD_DURATION: begin
                wr_next.t0 = now_reg;
                wr_next.tf = now_reg + dur_reg;
                wr_next.x0 = cur_reg;
                wr_next.xf = tgt_reg;
            end
            mjct_pkg::CMD_ENABLE: wr_next.en = en_reg;
            default: wr_next = rd_reg;
        endcase
    end

    assign bl_req   = '{t: now_reg, t0: rd_reg.t0, tf: rd_reg.tf,
                        x0: rd_reg.x0, xf: rd_reg.xf};
    assign bl_start = (state_reg == S_EVAL) && (cmd_reg == mjct_pkg::CMD_TICK)
                      && rd_reg.en && (now_reg < rd_reg.tf);

    mjct_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bl_start),
        .req     (bl_req),
        .done    (bl_done),
        .pos     (bl_pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            jc_reg    <= 6'd32;
            mv_reg    <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (cfg_we) begin
                jc_reg <= cfg_wdata;
            end
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (CW'(clr_reg) == nj - CW'(1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_cmd;
                        joint_reg <= s_joint;
                        tgt_reg   <= s_target_pos;
                        cur_reg   <= s_current_pos;
                        now_reg   <= s_now;
                        ws_reg    <= s_window_start;
                        we_reg    <= s_window_end;
                        dur_reg   <= s_duration;
                        en_reg    <= s_enable;
                        n_reg     <= n_act;
                        idx_reg   <= '0;
                        if (s_cmd == mjct_pkg::CMD_TICK) begin
                            addr_reg <= '0;
                            if (n_act != 6'd0) begin
                                state_reg <= S_READ;
                            end
                        end else if ({1'b0, s_joint} >= n_act) begin
                            mv_reg <= 1'b1;
                            mk_reg <= mjct_pkg::KIND_ACK;
                            mj_reg <= s_joint;
                            mp_reg <= '0;
                            mc_reg <= 1'b0;
                            ms_reg <= mjct_pkg::STATUS_RANGE;
                            ml_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            addr_reg  <= AW'(s_joint);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: state_reg <= S_EVAL;
                S_EVAL: begin
                    wr_reg    <= wr_next;
                    state_reg <= bl_start ? S_BLEND : S_WRITE;
                end
                S_BLEND: begin
                    if (bl_done) begin
                        wr_reg.xd <= bl_pos;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    mv_reg <= 1'b1;
                    mk_reg <= (cmd_reg == mjct_pkg::CMD_TICK) ? mjct_pkg::KIND_JOINT
                                                              : mjct_pkg::KIND_ACK;
                    mj_reg <= (cmd_reg == mjct_pkg::CMD_TICK) ? 5'(idx_reg) : joint_reg;
                    mp_reg <= wr_reg.xd;
                    mc_reg <= wr_reg.en;
                    ms_reg <= mjct_pkg::STATUS_OK;
                    ml_reg <= (cmd_reg != mjct_pkg::CMD_TICK) || (idx_reg + 6'd1 == n_reg);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result is taken, then advance
                    if (mv_reg && m_ready) begin
                        if (ml_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 6'd1;
                            addr_reg  <= addr_reg + AW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = mv_reg;
    assign m_kind         = mk_reg;
    assign m_joint_index  = mj_reg;
    assign m_desired_pos  = mp_reg;
    assign m_claims_joint = mc_reg;
    assign m_status       = ms_reg;
    assign m_last         = ml_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mv_reg)
        else $error("request accepted while result pending");
    a_range_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && ms_reg) |-> (mk_reg == mjct_pkg::KIND_ACK && !mc_reg))
        else $error("range error on non-ack result");
    a_blend_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        bl_done |-> state_reg == S_BLEND)
        else $error("blend finished outside blend state");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the multi-joint cubic trajectory block: random requests, predicted results.
`timescale 1ns / 100ps
module tb_top;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  joint;
        logic [31:0] target_pos;
        logic [31:0] current_pos;
        logic [31:0] now;
        logic [31:0] window_start;
        logic [31:0] window_end;
        logic [31:0] duration;
        logic        enable;
    } request_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  joint_index;
        logic [31:0] desired_pos;
        logic        claims_joint;
        logic        status;
        logic        last;
    } joint_result_t;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam int HOLD_CYCLES    = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [5:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    request_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_kind;
    logic [4:0] m_joint_index;
    logic [31:0] m_desired_pos;
    logic m_claims_joint, m_status, m_last;

    multi_joint_cubic_trajectory u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_req.cmd), .s_joint(s_req.joint),
        .s_target_pos(s_req.target_pos), .s_current_pos(s_req.current_pos),
        .s_now(s_req.now), .s_window_start(s_req.window_start),
        .s_window_end(s_req.window_end), .s_duration(s_req.duration),
        .s_enable(s_req.enable), .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_joint_index(m_joint_index), .m_desired_pos(m_desired_pos),
        .m_claims_joint(m_claims_joint), .m_status(m_status), .m_last(m_last)
    );

    // predictor state
    logic [5:0]  jc;
    logic [31:0] tbl_t0 [32];
    logic [31:0] tbl_tf [32];
    logic [31:0] tbl_x0 [32];
    logic [31:0] tbl_xf [32];
    logic        tbl_en [32];
    logic [31:0] tbl_xd [32];

    request_t      pending_reqs[$];
    joint_result_t expected_results[$];
    int  errors = 0;
    int  send_idle = 32, recv_idle = 73;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;
    int  hold_cnt = 0;
    int  stall_cnt = 0;
    int  n_results = 0, n_ticks = 0, n_rejects = 0;
    int  jc_plan = 31;
    logic in_acc = 1'b0;
    logic timed_out = 1'b0;

    function automatic logic [31:0] cubic_position(logic [31:0] t, logic [31:0] t0,
                                                   logic [31:0] tf, logic [31:0] x0,
                                                   logic [31:0] xf);
        logic [63:0] num, den, s, s2, s3, h, mag, off;
        logic signed [33:0] delta, res;
        if (t < t0) return x0;
        num = {32'd0, t - t0};
        den = {32'd0, tf - t0};
        s = (num << 32) / den;
        s2 = (s * s) >> 32;
        s3 = (s2 * s) >> 32;
        h = 3 * s2 - 2 * s3;
        if (h > 64'h1_0000_0000) h = 64'h1_0000_0000;
        delta = $signed({{2{xf[31]}}, xf}) - $signed({{2{x0[31]}}, x0});
        mag = delta[33] ? 64'(-delta) : 64'(delta);
        off = (mag * h) >> 32;
        res = delta[33] ? $signed({{2{x0[31]}}, x0}) - $signed({2'b0, off[31:0]})
                        : $signed({{2{x0[31]}}, x0}) + $signed({2'b0, off[31:0]});
        return res[31:0];
    endfunction

    function automatic int joints_in_use();
        return (jc > 32) ? 32 : int'(jc);
    endfunction

    task automatic predict_request(request_t r);
        int n;
        joint_result_t e;
        n = joints_in_use();
        if (r.cmd == mjct_pkg::CMD_TICK) begin
            n_ticks++;
            for (int i = 0; i < n; i++) begin
                if (tbl_en[i]) begin
                    if (r.now >= tbl_tf[i]) begin
                        tbl_xd[i] = tbl_xf[i];
                        tbl_en[i] = 1'b0;
                    end else begin
                        tbl_xd[i] = cubic_position(r.now, tbl_t0[i], tbl_tf[i],
                                                   tbl_x0[i], tbl_xf[i]);
                    end
                end
                e = '{mjct_pkg::KIND_JOINT, 5'(i), tbl_xd[i], tbl_en[i],
                      mjct_pkg::STATUS_OK, i == n - 1};
                expected_results.push_back(e);
            end
        end else if (int'(r.joint) >= n) begin
            n_rejects++;
            expected_results.push_back('{mjct_pkg::KIND_ACK, r.joint, 32'd0, 1'b0,
                                         mjct_pkg::STATUS_RANGE, 1'b1});
        end else begin
            if (r.cmd == mjct_pkg::CMD_ENABLE) begin
                tbl_en[r.joint] = r.enable;
            end else begin
                if (r.cmd == mjct_pkg::CMD_WINDOW) begin
                    tbl_t0[r.joint] = r.window_start;
                    tbl_tf[r.joint] = r.window_end;
                end else begin
                    tbl_t0[r.joint] = r.now;
                    tbl_tf[r.joint] = r.now + r.duration;
                end
                tbl_x0[r.joint] = r.current_pos;
                tbl_xf[r.joint] = r.target_pos;
            end
            expected_results.push_back('{mjct_pkg::KIND_ACK, r.joint, tbl_xd[r.joint],
                                         tbl_en[r.joint], mjct_pkg::STATUS_OK, 1'b1});
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // driver: hold a request until the last rising edge took it
    always @(negedge aclk) begin
        if (s_valid && !in_acc) begin
            // hold
        end else if (pending_reqs.size() != 0 && aresetn
                     && $urandom_range(99) >= send_idle) begin
            s_req <= pending_reqs.pop_front();
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off when asked for
    always @(negedge aclk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        joint_result_t e;
        in_acc <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt <= 0;
            else stall_cnt <= stall_cnt + 1;
            if (s_valid && s_ready) predict_request(s_req);
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result joint %0d", m_joint_index);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_kind !== e.kind) begin
                        $error("kind exp %0h got %0h", e.kind, m_kind); errors++;
                    end
                    if (m_joint_index !== e.joint_index) begin
                        $error("joint_index exp %0d got %0d", e.joint_index, m_joint_index);
                        errors++;
                    end
                    if (m_desired_pos !== e.desired_pos) begin
                        $error("desired_pos exp %0h got %0h", e.desired_pos, m_desired_pos);
                        errors++;
                    end
                    if (m_claims_joint !== e.claims_joint) begin
                        $error("claims_joint exp %0h got %0h", e.claims_joint, m_claims_joint);
                        errors++;
                    end
                    if (m_status !== e.status) begin
                        $error("status exp %0h got %0h", e.status, m_status); errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last exp %0h got %0h", e.last, m_last); errors++;
                    end
                end
            end
        end
    end

    function automatic request_t make_req(mjct_pkg::cmd_t c, logic [4:0] j);
        request_t r;
        r.cmd = c;
        r.joint = j;
        r.target_pos = $urandom;
        r.current_pos = $urandom;
        r.now = $urandom;
        r.window_start = $urandom;
        r.window_end = $urandom;
        r.duration = $urandom;
        r.enable = $urandom_range(1);
        return r;
    endfunction

    // count random requests on random joints near time base tb_base, with tick times walking forward
    task automatic queue_random(int count, int tb_base);
        request_t r;
        int t;
        t = tb_base;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    r = make_req(mjct_pkg::CMD_TICK, 5'($urandom));
                    t = t + $urandom_range(40);
                    r.now = (k % 7 == 0) ? $urandom : t;
                end
                3, 4: begin
                    r = make_req(mjct_pkg::CMD_WINDOW, 5'($urandom_range(jc_plan)));
                    r.window_start = t + $urandom_range(20) - 10;
                    r.window_end = r.window_start + $urandom_range(200);
                    if (k % 11 == 0) r.window_end = $urandom;
                end
                5, 6: begin
                    r = make_req(mjct_pkg::CMD_DURATION, 5'($urandom_range(jc_plan)));
                    r.now = t;
                    r.duration = (k % 13 == 0) ? $urandom : $urandom_range(300);
                end
                default: begin
                    r = make_req(mjct_pkg::CMD_ENABLE, 5'($urandom_range(jc_plan)));
                    r.enable = ($urandom_range(3) != 0);
                end
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
            if (stall_cnt > TIMEOUT_CYCLES) begin
                timed_out = 1'b1;
                return;
            end
        end
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_count(logic [5:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        jc = v;
    endtask

    initial begin
        request_t r;
        logic [5:0] counts [4] = '{6'd4, 6'd1, 6'd32, 6'd9};
        jc = 6'd32;
        for (int i = 0; i < 32; i++) begin
            tbl_t0[i] = 0; tbl_tf[i] = 0; tbl_x0[i] = 0; tbl_xf[i] = 0;
            tbl_en[i] = 0; tbl_xd[i] = 0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, reject, wrap, before-window, end-before-start
        write_count(6'd3);
        r = make_req(mjct_pkg::CMD_WINDOW, 5'd0);
        r.window_start = 100; r.window_end = 200;
        r.current_pos = 32'h8000_0000; r.target_pos = 32'h7fff_ffff;
        pending_reqs.push_back(r);
        r = make_req(mjct_pkg::CMD_DURATION, 5'd1);
        r.now = 32'hffff_fff0; r.duration = 32'h40;
        r.current_pos = 32'h7fff_ffff; r.target_pos = 32'h8000_0000;
        pending_reqs.push_back(r);
        r = make_req(mjct_pkg::CMD_WINDOW, 5'd2);
        r.window_start = 500; r.window_end = 400;
        pending_reqs.push_back(r);
        for (int i = 0; i < 3; i++) begin
            r = make_req(mjct_pkg::CMD_ENABLE, 5'(i)); r.enable = 1'b1;
            pending_reqs.push_back(r);
        end
        r = make_req(mjct_pkg::CMD_ENABLE, 5'd31); pending_reqs.push_back(r);
        r = make_req(mjct_pkg::CMD_WINDOW, 5'd3); pending_reqs.push_back(r);
        foreach (counts[i]) begin
            r = make_req(mjct_pkg::CMD_TICK, 5'd0);
            r.now = (i == 0) ? 32'd50 : (i == 1) ? 32'd150 : (i == 2) ? 32'd199 : 32'd0;
            pending_reqs.push_back(r);
        end
        r = make_req(mjct_pkg::CMD_TICK, 5'd0); r.now = 32'hffff_ffff;
        pending_reqs.push_back(r);
        r = make_req(mjct_pkg::CMD_TICK, 5'd0); r.now = 32'h0000_0010;
        pending_reqs.push_back(r);
        wait_idle();

        // long receiver hold-off while requests keep coming
        write_count(6'd32);
        hold_req = 1'b1;
        queue_random(20, 1000);
        wait_idle();

        for (int ph = 0; ph < 4 && !timed_out; ph++) begin
            write_count(counts[ph]);
            jc_plan = (counts[ph] == 32) ? 31 : int'(counts[ph]) + 1;
            if (ph == 2) begin send_idle = 73; recv_idle = 32; end
            if (ph == 3) begin send_idle = 0; recv_idle = 0; end
            queue_random(50, $urandom_range(100000));
            wait_idle();
        end

        if (!timed_out) begin
            write_count(6'd0);
            r = make_req(mjct_pkg::CMD_TICK, 5'd0); pending_reqs.push_back(r);
            r = make_req(mjct_pkg::CMD_ENABLE, 5'd0); pending_reqs.push_back(r);
            wait_idle();
        end

        if (!timed_out && expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        $display("covered %0d ticks, %0d rejected sets, %0d results checked",
                 n_ticks, n_rejects, n_results);
        $display("joint counts 0, 1, 3, 4, 9 and 32; long result stall included");
        if (timed_out) begin
            $display("tb_top: errors");
        end else if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
